// ===== hw/rtl/gprp_pkg.sv =====
// ---------------------------------------------------------------------------
// gprp_pkg
// Shared types, constants and table functions for the grid point rotate and
// project block.
// ---------------------------------------------------------------------------
package gprp_pkg;

    // Default sizes for the top level parameters
    localparam int ANGLE_BITS_DEF      = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Configuration register widths and reset values
    localparam int PAD_W   = 16;
    localparam int ZST_W   = 18;
    localparam int CNT_W   = 5;
    localparam int SCR_W   = 12;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 18;

    localparam logic [PAD_W-1:0] PAD_RST = 16'd5461;
    localparam logic [ZST_W-1:0] ZST_RST = 18'd32768;
    localparam logic [CNT_W-1:0] CNT_RST = 5'd6;
    localparam logic [SCR_W-1:0] SW_RST  = 12'd800;
    localparam logic [SCR_W-1:0] SH_RST  = 12'd600;

    // Datapath widths
    localparam int HALF_W = 20;   // half grid size, unsigned
    localparam int PT_W   = 21;   // centred point coordinate, signed
    localparam int TRIG_W = 18;   // Q1.16 sine and cosine, signed
    localparam int TAB_W  = 17;   // quarter-wave table entry, unsigned
    localparam int PROD_W = PT_W + TRIG_W;
    localparam int ROT_W  = 23;   // rotated coordinate, signed
    localparam int Z_W    = 24;   // rotated depth, signed
    localparam int ZD_W   = 22;   // positive depth as divisor
    localparam int NUM_W  = 22;   // magnitude of a numerator
    localparam int DIV_DW = NUM_W + 16;
    localparam int QS_W   = DIV_DW + 1;
    localparam int CLP_W  = 35;   // clamped offset quotient
    localparam int SCL_W  = CLP_W + SCR_W + 1;
    localparam int OUT_W  = 16;
    localparam int SAT_LIM = 32767;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    // Register map
    typedef enum logic [CFG_AW-1:0] {
        REG_SPACING       = 3'd0,
        REG_Z_START       = 3'd1,
        REG_AXIS_PTS      = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4
    } t_reg_idx;

    // Request codes
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_POINT = 1'b1
    } t_req;

    // Back end sequencer
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SIN,
        BK_COS,
        BK_MUL_A,
        BK_MUL_B,
        BK_DEPTH,
        BK_DIV,
        BK_SCALE_A,
        BK_SCALE_B
    } t_back_state;

    typedef struct packed {
        logic [PAD_W-1:0] spacing;
        logic [ZST_W-1:0] z_start;
        logic [CNT_W-1:0] axis_pts;
        logic [SCR_W-1:0] screen_w;
        logic [SCR_W-1:0] screen_h;
    } t_cfg;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] dz;
    } t_point;

    // Half of the grid size; a zero count acts as one
    function automatic logic [HALF_W-1:0] calc_half(input logic [CNT_W-1:0] cnt,
                                                    input logic [PAD_W-1:0] pad);
        logic [CNT_W-1:0]    eff;
        logic [HALF_W:0]     size;
        eff  = (cnt == '0) ? CNT_W'(1) : cnt;
        size = (HALF_W+1)'(eff - CNT_W'(1)) * (HALF_W+1)'(pad);
        return size[HALF_W:1];
    endfunction

    // Quarter-wave sine entry built by a fixed-point Taylor series
    function automatic longint taylor_sin(input int unsigned k, input int unsigned stb);
        longint unsigned th;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        bit              neg;
        th   = (64'(k) * TWO_PI_Q30 + (64'd1 << (stb - 1))) >> stb;
        x2   = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        neg  = 1'b1;
        for (int n = 3; n <= 21; n += 2) begin
            term = ((term * x2) >> 30) / 64'((n - 1) * n);
            sum  = neg ? sum - longint'(term) : sum + longint'(term);
            neg  = !neg;
        end
        if (sum < 0) begin
            sum = 0;
        end
        return (sum + 64'sd8192) >>> 14;
    endfunction

endpackage

// ===== hw/rtl/gprp_front.sv =====
// ---------------------------------------------------------------------------
// gprp_front
// Accepts requests, keeps the yaw angle and forms centred grid points with
// their sine table index for the back end.
// ---------------------------------------------------------------------------
module gprp_front
    import gprp_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_req_type,
    input  logic [15:0]                i_dt,
    input  logic [3:0]                 i_ix,
    input  logic [3:0]                 i_iy,
    input  logic [3:0]                 i_iz,
    input  t_cfg                       i_cfg,
    output logic                       o_q_push,
    output t_point                     o_q_point,
    output logic [SINE_TABLE_BITS-1:0] o_q_idx
);

    localparam int SH_W = 16 + ANGLE_BITS;

    logic [ANGLE_BITS-1:0] r_yaw;
    logic [ANGLE_BITS-1:0] n_yaw;
    logic [SH_W-1:0]       w_shift;
    logic [ANGLE_BITS-1:0] w_inc;
    logic [HALF_W-1:0]     w_half;

    // Angle step of dt/8 turns
    assign w_shift = SH_W'(i_dt) << ANGLE_BITS;
    assign w_inc   = ANGLE_BITS'(w_shift >> 19);

    always_comb begin
        n_yaw = r_yaw;
        if (i_accept && (i_req_type == REQ_TICK)) begin
            n_yaw = r_yaw + w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw <= '0;
        end else begin
            r_yaw <= n_yaw;
        end
    end

    // Scale the angle to the table index
    generate
        if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_idx_down
            assign o_q_idx = r_yaw[ANGLE_BITS-1 -: SINE_TABLE_BITS];
        end else begin : g_idx_up
            assign o_q_idx = {r_yaw, {(SINE_TABLE_BITS-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    // Centre the point on the grid
    assign w_half = calc_half(i_cfg.axis_pts, i_cfg.spacing);

    always_comb begin
        o_q_point.x  = signed'(PT_W'(i_ix) * PT_W'(i_cfg.spacing)) - signed'(PT_W'(w_half));
        o_q_point.y  = signed'(PT_W'(i_iy) * PT_W'(i_cfg.spacing)) - signed'(PT_W'(w_half));
        o_q_point.dz = signed'(PT_W'(i_iz) * PT_W'(i_cfg.spacing)) - signed'(PT_W'(w_half));
    end

    assign o_q_push = i_accept && (i_req_type == REQ_POINT);

endmodule

// ===== hw/rtl/gprp_queue.sv =====
// ---------------------------------------------------------------------------
// gprp_queue
// Two-entry queue between the front and back ends.
// ---------------------------------------------------------------------------
module gprp_queue
    import gprp_pkg::*;
#(
    parameter int WIDTH = 3 * PT_W + SINE_TABLE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // Store pushed entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== hw/rtl/gprp_div.sv =====
// ---------------------------------------------------------------------------
// gprp_div
// Unsigned restoring divider, two quotient bits per cycle.
// ---------------------------------------------------------------------------
module gprp_div
    import gprp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_DW-1:0] i_dividend,
    input  logic [ZD_W-1:0]   i_divisor,
    output logic              o_busy,
    output logic [DIV_DW-1:0] o_quotient
);

    localparam int STEPS = DIV_DW / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DIV_DW-1:0] r_quo;
    logic [ZD_W-1:0]   r_rem;
    logic [ZD_W-1:0]   r_den;
    logic [CW-1:0]     r_cnt;
    logic [DIV_DW-1:0] n_quo;
    logic [ZD_W-1:0]   n_rem;

    // Two restoring steps
    always_comb begin
        logic [ZD_W:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            t     = {n_rem, n_quo[DIV_DW-1]};
            n_quo = n_quo << 1;
            if (t >= {1'b0, r_den}) begin
                n_rem    = ZD_W'(t - {1'b0, r_den});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = ZD_W'(t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/gprp_back.sv =====
// ---------------------------------------------------------------------------
// gprp_back
// Rotates queued points by table sine and cosine, divides by depth and maps
// to screen pixels into the result register.
// ---------------------------------------------------------------------------
module gprp_back
    import gprp_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    output logic                       o_q_pop,
    input  t_point                     i_q_point,
    input  logic [SINE_TABLE_BITS-1:0] i_q_idx,
    input  t_cfg                       i_cfg,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [OUT_W-1:0]    o_screen_x,
    output logic signed [OUT_W-1:0]    o_screen_y,
    output logic                       o_behind_camera
);

    localparam int SB    = SINE_TABLE_BITS;
    localparam int SIN_Q = 1 << (SB - 2);

    t_back_state r_state;
    t_back_state n_state;

    logic                     w_start_div;
    logic                     w_load_out;
    t_point                   r_pt;
    logic [SB-1:0]            r_idx;
    logic signed [TRIG_W-1:0] r_s;
    logic signed [TRIG_W-1:0] r_c;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [ROT_W-1:0]  r_rx;
    logic                     r_behind;
    logic                     r_negx;
    logic                     r_negy;
    logic signed [SCL_W-1:0]  r_mx;
    logic signed [SCL_W-1:0]  r_my;
    logic                     r_ovalid;
    logic signed [OUT_W-1:0]  r_ox;
    logic signed [OUT_W-1:0]  r_oy;
    logic                     r_ob;

    // Quarter-wave sine table
    logic [TAB_W-1:0] w_tab [SIN_Q+1];
    generate
        for (genvar g = 0; g <= SIN_Q; g++) begin : g_tab
            assign w_tab[g] = TAB_W'(taylor_sin(g, SB));
        end
    endgenerate

    // Fold the index into the quarter wave
    logic [SB-1:0]            w_lidx;
    logic [SB-3:0]            w_r;
    logic [SB-2:0]            w_ti;
    logic signed [TRIG_W-1:0] w_trig;
    always_comb begin
        w_lidx = (r_state == BK_COS) ? r_idx + SB'(SIN_Q) : r_idx;
        w_r    = w_lidx[SB-3:0];
        w_ti   = w_lidx[SB-2] ? (SB-1)'(SIN_Q) - {1'b0, w_r} : {1'b0, w_r};
        w_trig = signed'({1'b0, w_tab[w_ti]});
        if (w_lidx[SB-1]) begin
            w_trig = -w_trig;
        end
    end

    // Rotated depth and divider operands
    logic signed [PROD_W:0]  w_sum;
    logic signed [ROT_W-1:0] w_rz;
    logic signed [Z_W-1:0]   w_z;
    logic                    w_zpos;
    logic [NUM_W-1:0]        w_ax;
    logic [NUM_W-1:0]        w_ay;
    always_comb begin
        w_sum  = (PROD_W+1)'(r_p1) + (PROD_W+1)'(r_p2);
        w_rz   = ROT_W'(w_sum >>> 16);
        w_z    = Z_W'(w_rz) + signed'(Z_W'(i_cfg.z_start))
               + signed'(Z_W'(calc_half(i_cfg.axis_pts, i_cfg.spacing)));
        w_zpos = !w_z[Z_W-1] && (w_z != '0);
        w_ax   = r_rx[ROT_W-1] ? NUM_W'(-r_rx) : NUM_W'(r_rx);
        w_ay   = r_pt.y[PT_W-1] ? NUM_W'(-r_pt.y) : NUM_W'(r_pt.y);
    end

    logic              w_bx;
    logic              w_by;
    logic [DIV_DW-1:0] w_qx;
    logic [DIV_DW-1:0] w_qy;

    gprp_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_div),
        .i_dividend ({w_ax, 16'd0}),
        .i_divisor  (ZD_W'(w_z)),
        .o_busy     (w_bx),
        .o_quotient (w_qx)
    );

    gprp_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start_div),
        .i_dividend ({w_ay, 16'd0}),
        .i_divisor  (ZD_W'(w_z)),
        .o_busy     (w_by),
        .o_quotient (w_qy)
    );

    // Offset and clamp a quotient; beyond the clamp the pixel saturates anyway
    function automatic logic signed [CLP_W-1:0] clamp_q(input logic [DIV_DW-1:0] mag,
                                                         input logic neg);
        logic signed [QS_W-1:0]  qs;
        logic signed [QS_W:0]    t;
        qs = neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        t  = (QS_W+1)'(qs) + (QS_W+1)'(65536);
        if (t > (QS_W+1)'(64'sd1 <<< 33)) begin
            t = (QS_W+1)'(64'sd1 <<< 33);
        end else if (t < -((QS_W+1)'(64'sd1 <<< 33))) begin
            t = -((QS_W+1)'(64'sd1 <<< 33));
        end
        return CLP_W'(t);
    endfunction

    // Divide by 2^17 toward zero and saturate
    function automatic logic signed [OUT_W-1:0] to_pix(input logic signed [SCL_W-1:0] p);
        logic signed [SCL_W-1:0]  adj;
        logic signed [SCL_W-18:0] sh;
        adj = p[SCL_W-1] ? p + SCL_W'(131071) : p;
        sh  = (SCL_W-17)'(adj >>> 17);
        if (sh > (SCL_W-17)'(SAT_LIM)) begin
            return OUT_W'(SAT_LIM);
        end else if (sh < -((SCL_W-17)'(SAT_LIM))) begin
            return -OUT_W'(SAT_LIM);
        end
        return OUT_W'(sh);
    endfunction

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one point
    always_comb begin
        n_state     = r_state;
        o_q_pop     = 1'b0;
        w_start_div = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = BK_SIN;
                end
            end
            BK_SIN:   n_state = BK_COS;
            BK_COS:   n_state = BK_MUL_A;
            BK_MUL_A: n_state = BK_MUL_B;
            BK_MUL_B: n_state = BK_DEPTH;
            BK_DEPTH: begin
                if (w_zpos) begin
                    w_start_div = 1'b1;
                    n_state     = BK_DIV;
                end else begin
                    n_state = BK_SCALE_B;
                end
            end
            BK_DIV: begin
                if (!w_bx && !w_by) begin
                    n_state = BK_SCALE_A;
                end
            end
            BK_SCALE_A: n_state = BK_SCALE_B;
            BK_SCALE_B: begin
                if (!r_ovalid || i_pop) begin
                    w_load_out = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_pt  <= i_q_point;
                r_idx <= i_q_idx;
            end
            BK_SIN: r_s <= w_trig;
            BK_COS: r_c <= w_trig;
            BK_MUL_A: begin
                r_p1 <= r_pt.x * r_c;
                r_p2 <= -(r_pt.dz * r_s);
            end
            BK_MUL_B: begin
                r_rx <= ROT_W'(((PROD_W+1)'(r_p1) + (PROD_W+1)'(r_p2)) >>> 16);
                r_p1 <= r_pt.x * r_s;
                r_p2 <= r_pt.dz * r_c;
            end
            BK_DEPTH: begin
                r_behind <= !w_zpos;
                r_negx   <= r_rx[ROT_W-1];
                r_negy   <= r_pt.y[PT_W-1];
            end
            BK_SCALE_A: begin
                r_mx <= clamp_q(w_qx, r_negx) * signed'({1'b0, i_cfg.screen_w});
                r_my <= clamp_q(w_qy, r_negy) * signed'({1'b0, i_cfg.screen_h});
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_ob <= r_behind;
            r_ox <= r_behind ? '0 : to_pix(r_mx);
            r_oy <= r_behind ? '0 : to_pix(r_my);
        end
    end

    assign o_empty         = !r_ovalid;
    assign o_screen_x      = r_ox;
    assign o_screen_y      = r_oy;
    assign o_behind_camera = r_ob;

endmodule

// ===== hw/rtl/grid_point_rotate_project.sv =====
// ---------------------------------------------------------------------------
// grid_point_rotate_project
// Yaw rotation and perspective projection of grid points to screen pixels.
// ---------------------------------------------------------------------------
// A tick request advances the yaw angle by dt/8 turns and gives no result. A
// point request is formed in the front end and queued (two entries); the back
// end then does table lookups of sine and cosine, two multiply steps and the
// depth sum; for a positive depth, two parallel dividers at two quotient bits a
// cycle and two scaling steps follow; a point behind the camera goes straight
// to the last step. The dividers set the point rate. Results wait in an output
// register so the back end can start the next point. Configuration must be
// written only while the block is idle; it is not enforced by the block.
module grid_point_rotate_project
    import gprp_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_AW-1:0]       i_cfg_addr,
    input  logic [CFG_DW-1:0]       i_cfg_wdata,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_req_type,
    input  logic [15:0]             i_dt,
    input  logic [3:0]              i_ix,
    input  logic [3:0]              i_iy,
    input  logic [3:0]              i_iz,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [OUT_W-1:0] o_screen_x,
    output logic signed [OUT_W-1:0] o_screen_y,
    output logic                    o_behind_camera
);

    localparam int QW = 3 * PT_W + SINE_TABLE_BITS;

    t_cfg r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spacing    <= PAD_RST;
            r_cfg.z_start    <= ZST_RST;
            r_cfg.axis_pts   <= CNT_RST;
            r_cfg.screen_w   <= SW_RST;
            r_cfg.screen_h   <= SH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SPACING:       r_cfg.spacing    <= i_cfg_wdata[PAD_W-1:0];
                REG_Z_START:       r_cfg.z_start    <= i_cfg_wdata[ZST_W-1:0];
                REG_AXIS_PTS:      r_cfg.axis_pts   <= i_cfg_wdata[CNT_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_w   <= i_cfg_wdata[SCR_W-1:0];
                REG_SCREEN_HEIGHT: r_cfg.screen_h   <= i_cfg_wdata[SCR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                       w_accept;
    logic                       w_q_push;
    t_point                     w_f_point;
    logic [SINE_TABLE_BITS-1:0] w_f_idx;
    logic [QW-1:0]              w_q_data;
    logic                       w_q_pop;
    logic                       w_q_empty;

    assign w_accept = push && !full;

    gprp_front #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .i_dt       (i_dt),
        .i_ix       (i_ix),
        .i_iy       (i_iy),
        .i_iz       (i_iz),
        .i_cfg      (r_cfg),
        .o_q_push   (w_q_push),
        .o_q_point  (w_f_point),
        .o_q_idx    (w_f_idx)
    );

    gprp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_f_idx, w_f_point}),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    gprp_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .o_q_pop         (w_q_pop),
        .i_q_point       (w_q_data[3*PT_W-1:0]),
        .i_q_idx         (w_q_data[QW-1 -: SINE_TABLE_BITS]),
        .i_cfg           (r_cfg),
        .i_pop           (pop && !empty),
        .o_empty         (empty),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_behind_camera (o_behind_camera)
    );

endmodule
